// ===== rtl/fscs_pkg.sv =====
// Shared types and constants for the circular-scroll frame store.
// Holds field widths, command, direction and register codes and the controller states.
// No dependencies.
`timescale 1ns / 1ps

package fscs_pkg;

    localparam int CMD_W       = 2;
    localparam int PIXEL_W     = 8;
    localparam int COORD_W     = 7;
    localparam int COLOR_W     = 24;
    localparam int STEP_W      = 8;
    localparam int DIR_W       = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_SCROLL = 2'd2,
        CMD_READ   = 2'd3
    } command_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } direction_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SCROLL_DIRECTION = 3'd0,
        REG_SCROLL_STEP      = 3'd1,
        REG_THRESHOLD        = 3'd2,
        REG_FOREGROUND_COLOR = 3'd3,
        REG_BACKGROUND_COLOR = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_RD_ADDR = 2'd1,
        ST_RD_DATA = 2'd2,
        ST_CLEAR   = 2'd3
    } state_t;

    localparam direction_t        DIR_RESET        = DIR_UP;
    localparam logic [STEP_W-1:0]  STEP_RESET       = 8'd2;
    localparam logic [PIXEL_W-1:0] THRESHOLD_RESET  = 8'd100;
    localparam logic [COLOR_W-1:0] FG_RESET         = 24'h000000;
    localparam logic [COLOR_W-1:0] BG_RESET         = 24'hFFFFFF;
    localparam logic [PIXEL_W-1:0] CLEAR_VALUE      = 8'hFF;

endpackage

// ===== rtl/frame_store_circular_scroll_top.sv =====
// Top level of the circular-scroll frame store: memory, offset registers and controller.
// Depends on fscs_pkg.
`timescale 1ns / 1ps

// Usage.
// Requests enter on the in channel (in_valid, in_stall) with command, pixel_value,
// x_pos and y_pos; read results leave on the out channel (out_valid, out_stall) with
// pixel_color and stored_value. Registers are written through cfg_write_en, cfg_index
// and cfg_data; the user must write them only while the block is idle, as the block
// does not enforce it. Load and scroll requests may follow back to back: a scroll only
// moves the column and row offsets, and a load writes one entry unless the window is full.
// A read passes ST_RD_ADDR, which registers the memory read data, and ST_RD_DATA,
// which fills the output register; no request is accepted until the read is done.
// A clear sweeps all FRAME_SIDE * FRAME_SIDE entries (16384 by default) with 255,
// one entry a cycle; no request is accepted meanwhile.
// After reset the offsets and load pointer are zero and the registers hold their
// reset values; the memory content is undefined until a clear or loads reach it.
// A stalled result is held in the output register; the block may accept further
// requests meanwhile, and a read waits for the output register before finishing.
module frame_store_circular_scroll_top #(
    parameter int FRAME_SIDE   = 128,
    parameter int IMAGE_WIDTH  = 96,
    parameter int IMAGE_HEIGHT = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [fscs_pkg::CMD_W-1:0]         command,
    input  logic [fscs_pkg::PIXEL_W-1:0]       pixel_value,
    input  logic [fscs_pkg::COORD_W-1:0]       x_pos,
    input  logic [fscs_pkg::COORD_W-1:0]       y_pos,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [fscs_pkg::COLOR_W-1:0]       pixel_color,
    output logic [fscs_pkg::PIXEL_W-1:0]       stored_value,
    input  logic                               cfg_write_en,
    input  logic [fscs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fscs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import fscs_pkg::*;

    localparam int DEPTH = FRAME_SIDE * FRAME_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(FRAME_SIDE);
    localparam int WIN_W = (IMAGE_WIDTH < FRAME_SIDE) ? IMAGE_WIDTH : FRAME_SIDE;
    localparam int WIN_H = (IMAGE_HEIGHT < FRAME_SIDE) ? IMAGE_HEIGHT : FRAME_SIDE;
    localparam int COL_W = $clog2(WIN_W + 1);
    localparam int ROW_W = $clog2(WIN_H + 1);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CW:0]      SIDE_EXT  = (CW + 1)'(FRAME_SIDE);
    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(WIN_W - 1);
    localparam logic [ROW_W-1:0] FULL_ROW  = ROW_W'(WIN_H);

    logic [CW-1:0] step_mod_tab  [2**STEP_W];
    logic [CW-1:0] coord_mod_tab [2**COORD_W];

    for (genvar i = 0; i < 2**STEP_W; i++)
    begin : g_step_tab
        assign step_mod_tab[i] = CW'(i % FRAME_SIDE);
    end

    for (genvar i = 0; i < 2**COORD_W; i++)
    begin : g_coord_tab
        assign coord_mod_tab[i] = CW'(i % FRAME_SIDE);
    end

    function automatic logic [CW-1:0] add_mod(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= SIDE_EXT)
        begin
            t = t - SIDE_EXT;
        end
        return t[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] sub_mod(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] t;
        if (a >= b)
        begin
            t = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            t = {1'b0, a} + SIDE_EXT - {1'b0, b};
        end
        return t[CW-1:0];
    endfunction

    function automatic logic [AW-1:0] flat_addr(input logic [CW-1:0] px, input logic [CW-1:0] py);
        return AW'(py) * AW'(FRAME_SIDE) + AW'(px);
    endfunction

    command_t cmd;
    logic     in_accept;

    state_t state_reg, state_next;
    logic [CW-1:0]    x_off_reg, x_off_next;
    logic [CW-1:0]    y_off_reg, y_off_next;
    logic [COL_W-1:0] load_col_reg, load_col_next;
    logic [ROW_W-1:0] load_row_reg, load_row_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_load;
    logic             rd_capture;

    logic [CW-1:0]      rd_px_reg, rd_py_reg;
    logic [PIXEL_W-1:0] mem_q_reg;
    logic [COLOR_W-1:0] pixel_color_reg;
    logic [PIXEL_W-1:0] stored_value_reg;

    direction_t         scroll_direction_reg;
    logic [STEP_W-1:0]  scroll_step_reg;
    logic [PIXEL_W-1:0] threshold_reg;
    logic [COLOR_W-1:0] foreground_color_reg;
    logic [COLOR_W-1:0] background_color_reg;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [PIXEL_W-1:0] mem_wdata;
    logic               mem_re;
    logic [PIXEL_W-1:0] mem [DEPTH];

    logic [CW-1:0] step_mod;

    assign cmd       = command_t'(command);
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign step_mod  = step_mod_tab[scroll_step_reg];

    assign out_valid    = out_valid_reg;
    assign pixel_color  = pixel_color_reg;
    assign stored_value = stored_value_reg;

    always_comb
    begin
        state_next     = state_reg;
        x_off_next     = x_off_reg;
        y_off_next     = y_off_reg;
        load_col_next  = load_col_reg;
        load_row_next  = load_row_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_load       = 1'b0;
        rd_capture     = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = clr_addr_reg;
        mem_wdata      = CLEAR_VALUE;
        mem_re         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (cmd)
                        CMD_CLEAR:
                        begin
                            x_off_next    = '0;
                            y_off_next    = '0;
                            load_col_next = '0;
                            load_row_next = '0;
                            clr_addr_next = '0;
                            state_next    = ST_CLEAR;
                        end
                        CMD_LOAD:
                        begin
                            if (load_row_reg != FULL_ROW)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = pixel_value;
                                mem_waddr = flat_addr(sub_mod(CW'(load_col_reg), x_off_reg),
                                                      sub_mod(CW'(load_row_reg), y_off_reg));
                                if (load_col_reg == LAST_COL)
                                begin
                                    load_col_next = '0;
                                    load_row_next = load_row_reg + 1'b1;
                                end
                                else
                                begin
                                    load_col_next = load_col_reg + 1'b1;
                                end
                            end
                        end
                        CMD_SCROLL:
                        begin
                            case (scroll_direction_reg)
                                DIR_RIGHT: x_off_next = add_mod(x_off_reg, step_mod);
                                DIR_LEFT:  x_off_next = sub_mod(x_off_reg, step_mod);
                                DIR_DOWN:  y_off_next = add_mod(y_off_reg, step_mod);
                                default:   y_off_next = sub_mod(y_off_reg, step_mod);
                            endcase
                        end
                        default:
                        begin
                            rd_capture = 1'b1;
                            state_next = ST_RD_ADDR;
                        end
                    endcase
                end
            end
            ST_RD_ADDR:
            begin
                mem_re     = 1'b1;
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            x_off_reg     <= '0;
            y_off_reg     <= '0;
            load_col_reg  <= '0;
            load_row_reg  <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            x_off_reg     <= x_off_next;
            y_off_reg     <= y_off_next;
            load_col_reg  <= load_col_next;
            load_row_reg  <= load_row_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_direction_reg <= DIR_RESET;
            scroll_step_reg      <= STEP_RESET;
            threshold_reg        <= THRESHOLD_RESET;
            foreground_color_reg <= FG_RESET;
            background_color_reg <= BG_RESET;
        end
        else if (cfg_write_en)
        begin
            case (reg_index_t'(cfg_index))
                REG_SCROLL_DIRECTION: scroll_direction_reg <= direction_t'(cfg_data[DIR_W-1:0]);
                REG_SCROLL_STEP:      scroll_step_reg      <= cfg_data[STEP_W-1:0];
                REG_THRESHOLD:        threshold_reg        <= cfg_data[PIXEL_W-1:0];
                REG_FOREGROUND_COLOR: foreground_color_reg <= cfg_data[COLOR_W-1:0];
                REG_BACKGROUND_COLOR: background_color_reg <= cfg_data[COLOR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_capture)
        begin
            rd_px_reg <= sub_mod(coord_mod_tab[x_pos], x_off_reg);
            rd_py_reg <= sub_mod(coord_mod_tab[y_pos], y_off_reg);
        end
        if (out_load)
        begin
            pixel_color_reg  <= (mem_q_reg > threshold_reg) ? foreground_color_reg
                                                            : background_color_reg;
            stored_value_reg <= mem_q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[flat_addr(rd_px_reg, rd_py_reg)];
        end
    end

    // A read accepted with the output register empty sets out_valid without any wait.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && cmd == CMD_READ && !out_valid_reg) |-> ##3 out_valid_reg)
        else $error("read result did not appear on time");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_ADDR || state_reg == ST_RD_DATA) |-> !mem_we)
        else $error("memory written during a read");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (x_off_reg == '0 && y_off_reg == '0 &&
                                     load_row_reg == '0 && load_col_reg == '0))
        else $error("offsets or load pointer not cleared during the sweep");

    assert property (@(posedge clk) disable iff (!rst_n)
        (load_row_reg == FULL_ROW) |-> (load_col_reg == '0))
        else $error("load pointer past the window");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> ($stable(pixel_color_reg) && $stable(stored_value_reg)))
        else $error("stalled result changed");

endmodule

// ===== bench/frame_store_circular_scroll_top_tb.sv =====
// Self-checking testbench for frame_store_circular_scroll_top: clear, load, scroll and read
// requests are predicted against a bench-side copy of the frame store and every read is checked.
// Depends on fscs_pkg and the RTL of the block.
`timescale 1ns / 1ps

module frame_store_circular_scroll_top_tb;

    import fscs_pkg::*;

    localparam int SIDE       = 128;
    localparam int WIN_W      = 96;
    localparam int WIN_H      = 64;
    localparam int WIN_SIZE   = WIN_W * WIN_H;
    localparam int LONG_HOLD  = 400;

    typedef struct {
        command_t             cmd;
        logic [PIXEL_W-1:0]   pixel;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
    } request_t;

    typedef struct {
        logic [COLOR_W-1:0]   color;
        logic [PIXEL_W-1:0]   value;
    } pixel_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [CMD_W-1:0]       command = CMD_CLEAR;
    logic [PIXEL_W-1:0]     pixel_value = '0;
    logic [COORD_W-1:0]     x_pos = '0;
    logic [COORD_W-1:0]     y_pos = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [COLOR_W-1:0]     pixel_color;
    logic [PIXEL_W-1:0]     stored_value;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_SCROLL_DIRECTION;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    request_t               request_fifo[$];
    pixel_result_t          pending_pixels[$];
    request_t               active_request;
    int                     requests_queued = 0;
    int                     requests_taken = 0;
    int                     mismatch_count = 0;
    int                     long_holds_wanted = 0;
    int                     long_holds_served = 0;
    bit                     sender_gaps_on = 1'b1;
    bit                     receiver_stalls_on = 1'b1;
    int                     send_gap_left = 0;
    int                     stall_left = 0;
    int                     hold_left = 0;
    logic                   next_valid;
    logic                   next_stall;

    logic [PIXEL_W-1:0]     frame_bytes [SIDE*SIDE];
    logic [PIXEL_W-1:0]     shadow_bytes [SIDE*SIDE];
    int                     load_count = 0;
    direction_t             cur_direction = DIR_RESET;
    logic [STEP_W-1:0]      cur_step = STEP_RESET;
    logic [PIXEL_W-1:0]     cur_threshold = THRESHOLD_RESET;
    logic [COLOR_W-1:0]     cur_fg = FG_RESET;
    logic [COLOR_W-1:0]     cur_bg = BG_RESET;

    frame_store_circular_scroll_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .pixel_value  (pixel_value),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_color  (pixel_color),
        .stored_value (stored_value),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s: got %h, expected %h at %0t ns", what, got, want, $time);
        mismatch_count++;
    endtask

    task automatic apply_request(input request_t r);
        logic [COORD_W-1:0] rr;
        logic [COORD_W-1:0] cc;
        logic [COORD_W-1:0] s;
        logic [PIXEL_W-1:0] v;
        pixel_result_t      res;
        s = cur_step[COORD_W-1:0];
        case (r.cmd)
            CMD_CLEAR:
            begin
                foreach (frame_bytes[i])
                    frame_bytes[i] = CLEAR_VALUE;
                load_count = 0;
            end
            CMD_LOAD:
            begin
                if (load_count < WIN_SIZE)
                begin
                    frame_bytes[(load_count / WIN_W) * SIDE + (load_count % WIN_W)] = r.pixel;
                    load_count++;
                end
            end
            CMD_SCROLL:
            begin
                if (s != '0)
                begin
                    shadow_bytes = frame_bytes;
                    for (int row = 0; row < SIDE; row++)
                    begin
                        for (int col = 0; col < SIDE; col++)
                        begin
                            rr = row[COORD_W-1:0];
                            cc = col[COORD_W-1:0];
                            case (cur_direction)
                                DIR_RIGHT: cc = cc - s;
                                DIR_LEFT:  cc = cc + s;
                                DIR_UP:    rr = rr + s;
                                default:   rr = rr - s;
                            endcase
                            frame_bytes[row * SIDE + col] = shadow_bytes[{rr, cc}];
                        end
                    end
                end
            end
            default:
            begin
                v = frame_bytes[{r.y, r.x}];
                res.value = v;
                res.color = (v > cur_threshold) ? cur_fg : cur_bg;
                pending_pixels.push_back(res);
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap_left = 0;
        end
        else
        begin
            next_valid = in_valid;
            if (in_valid && !in_stall)
            begin
                apply_request(active_request);
                requests_taken++;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_gap_left > 0)
                    send_gap_left--;
                else if (sender_gaps_on && request_fifo.size() > 0
                         && $urandom_range(0, 99) < 12)
                    send_gap_left = $urandom_range(1, 10) - 1;
                else if (request_fifo.size() > 0)
                begin
                    active_request = request_fifo.pop_front();
                    command <= active_request.cmd;
                    pixel_value <= active_request.pixel;
                    x_pos <= active_request.x;
                    y_pos <= active_request.y;
                    next_valid = 1'b1;
                end
            end
            in_valid <= next_valid;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_pixels.size() == 0)
                    report_mismatch("unexpected result", 32'(pixel_color), 32'd0);
                else
                begin
                    if (pixel_color !== pending_pixels[0].color)
                        report_mismatch("pixel_color", 32'(pixel_color),
                                        32'(pending_pixels[0].color));
                    if (stored_value !== pending_pixels[0].value)
                        report_mismatch("stored_value", 32'(stored_value),
                                        32'(pending_pixels[0].value));
                    void'(pending_pixels.pop_front());
                end
            end
            if (long_holds_served != long_holds_wanted)
            begin
                hold_left = LONG_HOLD;
                long_holds_served++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_stall = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                next_stall = 1'b1;
            end
            else if (receiver_stalls_on && $urandom_range(0, 99) < 10)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                next_stall = 1'b1;
            end
            else
                next_stall = 1'b0;
            out_stall <= next_stall;
        end
    end

    task automatic push_request(input command_t c, input logic [PIXEL_W-1:0] pv,
                                input logic [COORD_W-1:0] xp, input logic [COORD_W-1:0] yp);
        request_t r;
        r.cmd = c;
        r.pixel = pv;
        r.x = xp;
        r.y = yp;
        request_fifo.push_back(r);
        requests_queued++;
    endtask

    // Only used once the whole store has been cleared, so any read position is valid.
    task automatic push_mix(input int count);
        int k;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 45)
                push_request(CMD_LOAD, PIXEL_W'($urandom), COORD_W'($urandom),
                             COORD_W'($urandom));
            else if (k < 58)
                push_request(CMD_SCROLL, PIXEL_W'($urandom), COORD_W'($urandom),
                             COORD_W'($urandom));
            else
                push_request(CMD_READ, PIXEL_W'($urandom), COORD_W'($urandom),
                             COORD_W'($urandom));
        end
    endtask

    task automatic wait_drained();
        while (requests_taken != requests_queued || pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure(input direction_t dir, input logic [STEP_W-1:0] step,
                             input logic [PIXEL_W-1:0] thr, input logic [COLOR_W-1:0] fg,
                             input logic [COLOR_W-1:0] bg);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= REG_SCROLL_DIRECTION;
        cfg_data <= CFG_DATA_W'(dir);
        @(posedge clk);
        cfg_index <= REG_SCROLL_STEP;
        cfg_data <= CFG_DATA_W'(step);
        @(posedge clk);
        cfg_index <= REG_THRESHOLD;
        cfg_data <= CFG_DATA_W'(thr);
        @(posedge clk);
        cfg_index <= REG_FOREGROUND_COLOR;
        cfg_data <= fg;
        @(posedge clk);
        cfg_index <= REG_BACKGROUND_COLOR;
        cfg_data <= bg;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        cur_direction = dir;
        cur_step = step;
        cur_threshold = thr;
        cur_fg = fg;
        cur_bg = bg;
    endtask

    initial
    begin
        logic [STEP_W-1:0]  step;
        logic [PIXEL_W-1:0] thr;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        foreach (frame_bytes[i])
            frame_bytes[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Loads straight after reset reach only the first row, so reads stay on those entries
        // until the store has been cleared.
        push_request(CMD_LOAD, 8'd0, 7'd5, 7'd9);
        push_request(CMD_LOAD, 8'd255, 7'd0, 7'd0);
        push_request(CMD_LOAD, 8'd100, 7'd127, 7'd127);
        push_request(CMD_LOAD, 8'd101, 7'd0, 7'd0);
        push_request(CMD_LOAD, 8'd99, 7'd0, 7'd0);
        push_request(CMD_LOAD, 8'h55, 7'd0, 7'd0);
        push_request(CMD_LOAD, 8'hAA, 7'd0, 7'd0);
        push_request(CMD_LOAD, 8'd1, 7'd0, 7'd0);
        push_request(CMD_LOAD, 8'd254, 7'd0, 7'd0);
        push_request(CMD_READ, 8'd0, 7'd0, 7'd0);
        push_request(CMD_READ, 8'd0, 7'd1, 7'd0);
        push_request(CMD_READ, 8'd0, 7'd2, 7'd0);
        push_request(CMD_READ, 8'd0, 7'd3, 7'd0);
        push_request(CMD_READ, 8'hFF, 7'd8, 7'd0);
        push_request(CMD_SCROLL, 8'd0, 7'd0, 7'd0);
        push_request(CMD_CLEAR, 8'd0, 7'd0, 7'd0);
        push_request(CMD_READ, 8'd0, 7'd0, 7'd0);
        push_request(CMD_READ, 8'd0, 7'd127, 7'd127);
        push_request(CMD_READ, 8'd0, 7'd127, 7'd0);
        push_request(CMD_READ, 8'd0, 7'd0, 7'd127);

        for (int p = 0; p < 14; p++)
        begin
            wait_drained();
            repeat (8) @(posedge clk);
            sender_gaps_on = (p != 13) && (p % 3 != 2);
            receiver_stalls_on = (p != 13) && (p % 4 != 1);
            case (p)
                0: step = 8'd1;
                1: step = 8'd254;
                2: step = 8'd0;
                3: step = 8'd128;
                4: step = 8'd127;
                5: step = 8'd255;
                6: step = 8'd129;
                default: step = STEP_W'($urandom_range(1, 254));
            endcase
            thr = (p == 1) ? 8'd0 : (p == 2) ? 8'd255 : 8'($urandom);
            fg = (p == 3) ? 24'h000000 : (p == 4) ? 24'hFFFFFF : 24'($urandom);
            bg = (p == 3) ? 24'hFFFFFF : (p == 4) ? 24'h000000 : 24'($urandom);
            configure(direction_t'(p % 4), step, thr, fg, bg);
            if (p == 3)
                long_holds_wanted++;
            if (p % 5 == 0 || p == 6)
                push_request(CMD_CLEAR, PIXEL_W'($urandom), COORD_W'($urandom),
                             COORD_W'($urandom));
            push_mix(70);
            wait_drained();
            push_mix(70);
            push_request(CMD_READ, PIXEL_W'($urandom), COORD_W'($urandom),
                         COORD_W'($urandom));
        end
        wait_drained();
        repeat (12) @(posedge clk);
        if (pending_pixels.size() != 0)
            report_mismatch("results never delivered", pending_pixels.size(), 0);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #32000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/fscs_pkg.sv
rtl/frame_store_circular_scroll_top.sv
bench/frame_store_circular_scroll_top_tb.sv
